[src/pidaw_pkg.sv]
// ============================================================================
// pidaw_pkg
// Shared types, constants and microcode for the PID controller with anti-windup.
// ============================================================================
package pidaw_pkg;

	localparam int ValW  = 16;
	localparam int ErrW  = 17;
	localparam int IncW  = 18;
	localparam int DifW  = 22;
	localparam int LimW  = 15;
	localparam int RawW  = 20;
	localparam int MulW  = 38;
	localparam int SumW  = 22;
	localparam int StepW = 3;
	localparam int AddrW = 3;

	localparam logic signed [ValW-1:0] StepNum = 16'sd6554;
	localparam logic signed [RawW-1:0] RawMax  = 20'sh7FFFF;
	localparam logic signed [RawW-1:0] RawMin  = 20'sh80000;
	localparam logic [LimW-1:0]        LimReset = 15'd4096;

	typedef enum logic [AddrW-1:0] {
		REG_TARGET_VALUE   = 3'd0,
		REG_GAIN_P         = 3'd1,
		REG_GAIN_I         = 3'd2,
		REG_GAIN_D         = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_DRIVE_LIMIT    = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP      = 4'd0,
		OP_LOAD_ERR = 4'd1,
		OP_DIF      = 4'd2,
		OP_INTEG    = 4'd3,
		OP_PTERM    = 4'd4,
		OP_WINDUP   = 4'd5,
		OP_SUM_D    = 4'd6,
		OP_SUM_I    = 4'd7,
		OP_OUT      = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		A_ERR   = 2'd0,
		A_INTEG = 2'd1,
		A_DIF   = 2'd2
	} asel_t;

	typedef enum logic [1:0] {
		B_STEP = 2'd0,
		B_GP   = 2'd1,
		B_GI   = 2'd2,
		B_GD   = 2'd3
	} bsel_t;

	typedef enum logic [1:0] {
		W_NONE = 2'd0,
		W_IN   = 2'd1,
		W_OUT  = 2'd2
	} wait_t;

	typedef struct packed {
		op_t              op;
		asel_t            a_sel;
		bsel_t            b_sel;
		logic             mul_en;
		wait_t            wait_sel;
		logic             jump;
		logic [StepW-1:0] target;
	} uword_t;

	typedef struct packed {
		op_t   op;
		asel_t a_sel;
		bsel_t b_sel;
		logic  mul_en;
		logic  fire;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_full;
	} stat_t;

	typedef struct packed {
		logic signed [ValW-1:0] target_value;
		logic signed [ValW-1:0] gain_p;
		logic signed [ValW-1:0] gain_i;
		logic signed [ValW-1:0] gain_d;
		logic [LimW-1:0]        integral_limit;
		logic [LimW-1:0]        drive_limit;
	} cfg_t;

	function automatic uword_t mk(input op_t op, input asel_t a, input bsel_t b,
			input logic mul_en, input wait_t w, input logic jump,
			input logic [StepW-1:0] target);
		uword_t u;
		u.op       = op;
		u.a_sel    = a;
		u.b_sel    = b;
		u.mul_en   = mul_en;
		u.wait_sel = w;
		u.jump     = jump;
		u.target   = target;
		return u;
	endfunction

	// Program: load error, step product, P product, P term, D product / windup,
	// I product / add D, add I, deliver.
	function automatic uword_t ucode(input logic [StepW-1:0] step);
		uword_t u;
		unique case (step)
			3'd0: u = mk(OP_LOAD_ERR, A_ERR,   B_STEP, 1'b0, W_IN,   1'b0, 3'd0);
			3'd1: u = mk(OP_DIF,      A_ERR,   B_STEP, 1'b1, W_NONE, 1'b0, 3'd0);
			3'd2: u = mk(OP_INTEG,    A_ERR,   B_GP,   1'b1, W_NONE, 1'b0, 3'd0);
			3'd3: u = mk(OP_PTERM,    A_ERR,   B_STEP, 1'b0, W_NONE, 1'b0, 3'd0);
			3'd4: u = mk(OP_WINDUP,   A_DIF,   B_GD,   1'b1, W_NONE, 1'b0, 3'd0);
			3'd5: u = mk(OP_SUM_D,    A_INTEG, B_GI,   1'b1, W_NONE, 1'b0, 3'd0);
			3'd6: u = mk(OP_SUM_I,    A_ERR,   B_STEP, 1'b0, W_NONE, 1'b0, 3'd0);
			3'd7: u = mk(OP_OUT,      A_ERR,   B_STEP, 1'b0, W_OUT,  1'b1, 3'd0);
		endcase
		return u;
	endfunction

	// Saturate a wide signed value to the 20-bit term range.
	function automatic logic signed [RawW-1:0] sat_raw(input logic signed [MulW:0] v);
		logic signed [RawW-1:0] r;
		if (v > (MulW+1)'(RawMax))
			r = RawMax;
		else if (v < (MulW+1)'(RawMin))
			r = RawMin;
		else
			r = v[RawW-1:0];
		return r;
	endfunction

endpackage

[src/pidaw_seq.sv]
// ============================================================================
// pidaw_seq
// Microcode sequencer: step counter, control ROM and wait/jump handling.
// ============================================================================
module pidaw_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  pidaw_pkg::stat_t stat,
	output pidaw_pkg::ctl_t  ctl,
	output logic            in_ready
);
	import pidaw_pkg::*;

	logic [StepW-1:0] step_q;
	uword_t           uw;
	logic             hold;

	assign uw = ucode(step_q);

	always_comb begin
		unique case (uw.wait_sel)
			W_IN:    hold = !stat.in_valid;
			W_OUT:   hold = stat.out_full;
			default: hold = 1'b0;
		endcase
	end

	assign in_ready   = (uw.wait_sel == W_IN);
	assign ctl.op     = uw.op;
	assign ctl.a_sel  = uw.a_sel;
	assign ctl.b_sel  = uw.b_sel;
	assign ctl.mul_en = uw.mul_en;
	assign ctl.fire   = !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (!hold) begin
			if (uw.jump) begin
				step_q <= uw.target;
			end else begin
				step_q <= step_q + StepW'(1);
			end
		end
	end

endmodule

[src/pidaw_datapath.sv]
// ============================================================================
// pidaw_datapath
// Shared multiplier, term rounding/saturation, state and output register.
// ============================================================================
module pidaw_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pidaw_pkg::cfg_t             cfg,
	input  pidaw_pkg::ctl_t             ctl,
	input  logic signed [15:0]          measured,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        out_full,
	output logic signed [15:0]          drive,
	output logic signed [19:0]          raw_drive
);
	import pidaw_pkg::*;

	logic signed [ErrW-1:0] err_q;
	logic signed [ErrW-1:0] prev_q;
	logic signed [DifW-1:0] dif10_q;
	logic signed [ValW-1:0] integ_q;
	logic signed [MulW-1:0] prod_q;
	logic signed [RawW-1:0] p_q;
	logic signed [SumW-1:0] sum_q;
	logic                   out_valid_q;
	logic signed [ValW-1:0] drive_q;
	logic signed [RawW-1:0] raw_q;

	logic signed [DifW-1:0] a_op;
	logic signed [ValW-1:0] b_op;
	logic signed [MulW-1:0] mul_p;
	logic signed [ErrW:0]   dif;
	logic signed [DifW-1:0] dif_x;
	logic signed [MulW:0]   r16;
	logic signed [MulW:0]   r8;
	logic signed [IncW-1:0] inc;
	logic signed [IncW-1:0] acc;
	logic signed [IncW-1:0] ilim;
	logic signed [IncW-1:0] integ_nx;
	logic signed [RawW-1:0] term;
	logic signed [RawW:0]   dlim;
	logic signed [RawW:0]   p_x;
	logic signed [RawW-1:0] raw_nx;
	logic signed [RawW:0]   raw_x;
	logic signed [RawW:0]   drv_x;
	logic                   do_op;

	assign do_op = ctl.fire;

	always_comb begin
		unique case (ctl.a_sel)
			A_ERR:   a_op = DifW'(err_q);
			A_INTEG: a_op = DifW'(integ_q);
			default: a_op = dif10_q;
		endcase
		unique case (ctl.b_sel)
			B_STEP: b_op = StepNum;
			B_GP:   b_op = cfg.gain_p;
			B_GI:   b_op = cfg.gain_i;
			B_GD:   b_op = cfg.gain_d;
		endcase
	end

	assign mul_p = a_op * b_op;

	// error difference times ten as shift-add
	assign dif   = (ErrW+1)'(err_q) - (ErrW+1)'(prev_q);
	assign dif_x = DifW'(dif);

	// round half up, then arithmetic shift
	assign r16 = (MulW+1)'(prod_q) + (MulW+1)'(40'sd32768);
	assign r8  = (MulW+1)'(prod_q) + (MulW+1)'(40'sd128);
	assign inc = r16[16 +: IncW];
	assign term = sat_raw(r8 >>> 8);

	assign acc  = IncW'(integ_q) + inc;
	assign ilim = $signed({3'b000, cfg.integral_limit});

	always_comb begin
		if (acc > ilim)
			integ_nx = ilim;
		else if (acc < -ilim)
			integ_nx = -ilim;
		else
			integ_nx = acc;
	end

	assign dlim   = $signed({6'b000000, cfg.drive_limit});
	assign p_x    = (RawW+1)'(p_q);
	assign raw_nx = sat_raw((MulW+1)'(sum_q));
	assign raw_x  = (RawW+1)'(raw_nx);

	always_comb begin
		if (raw_x > dlim)
			drv_x = dlim;
		else if (raw_x < -dlim)
			drv_x = -dlim;
		else
			drv_x = raw_x;
	end

	// scratch registers
	always_ff @(posedge clk) begin
		if (do_op && ctl.mul_en) begin
			prod_q <= mul_p;
		end
		if (do_op) begin
			unique case (ctl.op)
				OP_LOAD_ERR: err_q   <= ErrW'(cfg.target_value) - ErrW'(measured);
				OP_DIF:      dif10_q <= (dif_x <<< 3) + (dif_x <<< 1);
				OP_PTERM:    p_q     <= term;
				OP_SUM_D:    sum_q   <= SumW'(p_q) + SumW'(term);
				OP_SUM_I:    sum_q   <= sum_q + SumW'(term);
				OP_OUT: begin
					raw_q   <= raw_nx;
					drive_q <= drv_x[ValW-1:0];
				end
				default: ;
			endcase
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else if (do_op) begin
			unique case (ctl.op)
				OP_INTEG:  integ_q <= integ_nx[ValW-1:0];
				OP_WINDUP: begin
					if (p_x > dlim || p_x < -dlim) begin
						integ_q <= '0;
					end
				end
				OP_OUT:    prev_q <= err_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_op && ctl.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_full  = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign raw_drive = raw_q;

endmodule

[src/pid_controller_antiwindup_unit.sv]
// ============================================================================
// pid_controller_antiwindup_unit
// Fixed-point PID controller with integral clamp and anti-windup reset.
// ============================================================================
// Usage:
//   Slave stream carries one measurement (Q4.12) per transaction.
//   Master stream returns drive (clamped to +/- drive_limit) and raw_drive
//   (saturated unclamped sum) per transaction.
//   The user writes registers through cfg_we/cfg_addr/cfg_wdata only while idle (unenforced).
// Sequence:
//   Each item takes one accept step and seven microcode steps that share
//   a single 22x16 multiplier for the step, P, D and I products.
//   The final deliver step loads the result into the output register.
//   The next measurement is accepted while the previous result waits.
// Reset:
//   arst_n clears integral and previous error, loads register defaults
//   (gains and target zero, both limits 1.0) and empties the output.
// Stall:
//   If the output register is still held by the receiver, the final step
//   waits; no result is dropped.
// ============================================================================
module pid_controller_antiwindup_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] measured
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [15:0] drive, [35:16] raw_drive, [39:36] zero
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import pidaw_pkg::*;

	cfg_t                   cfg_q;
	ctl_t                   ctl;
	stat_t                  stat;
	logic                   out_full;
	logic signed [ValW-1:0] drive;
	logic signed [RawW-1:0] raw_drive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_value   <= '0;
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.integral_limit <= LimReset;
			cfg_q.drive_limit    <= LimReset;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_TARGET_VALUE:   cfg_q.target_value   <= cfg_wdata;
				REG_GAIN_P:         cfg_q.gain_p         <= cfg_wdata;
				REG_GAIN_I:         cfg_q.gain_i         <= cfg_wdata;
				REG_GAIN_D:         cfg_q.gain_d         <= cfg_wdata;
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_wdata[LimW-1:0];
				REG_DRIVE_LIMIT:    cfg_q.drive_limit    <= cfg_wdata[LimW-1:0];
				default: ;
			endcase
		end
	end

	assign stat.in_valid = s_axis_tvalid;
	assign stat.out_full = out_full;

	pidaw_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.ctl      (ctl),
		.in_ready (s_axis_tready)
	);

	pidaw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ctl       (ctl),
		.measured  (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_full  (out_full),
		.drive     (drive),
		.raw_drive (raw_drive)
	);

	assign m_axis_tdata = {4'b0000, raw_drive, drive};

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for pid_controller_antiwindup_unit. A bit-true PID
// model (integral clamp, anti-windup reset, saturating terms) predicts drive
// and raw_drive for every accepted measurement; results are compared in
// order. Directed cases cover extremes, zero limits, register truncation and
// ignored indexes, followed by randomized register settings with random
// stalls on both streams, a long output hold-off and a back-to-back tail.
// ============================================================================
module testbench;

	import pidaw_pkg::*;

	localparam logic [2:0] RegSpare0     = 3'd6;
	localparam logic [2:0] RegSpare1     = 3'd7;
	localparam int         WatchdogLimit = 2000;
	localparam int         MaxPrinted    = 40;

	typedef struct packed {
		logic signed [19:0] raw_drive;
		logic signed [15:0] drive;
	} drive_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [15:0] measured
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [15:0] drive, [35:16] raw_drive, [39:36] zero
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [15:0] cfg_wdata;

	// controller model: registers and loop state
	logic signed [15:0] sp_r, gp_r, gi_r, gd_r;
	logic [14:0]        ilim_r, dlim_r;
	logic signed [15:0] integ_r;
	logic signed [16:0] prev_err_r;

	drive_result_t pending_drive_q[$];
	drive_result_t head_r;
	logic [15:0]   last_meas;

	int errors          = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int settings_used   = 0;
	int idle_count      = 0;
	int hold_cycles     = 0;
	bit src_idle_en     = 1'b1;
	bit snk_idle_en     = 1'b1;

	pid_controller_antiwindup_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint round_q(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// One control step: updates integral and previous error, returns outputs.
	function automatic drive_result_t advance_pid(input logic signed [15:0] meas);
		longint err, acc, lim_i, lim_d, p_t, i_t, d_t, total, drv, raw_lo, raw_hi;
		drive_result_t r;
		raw_lo = longint'(RawMin);
		raw_hi = longint'(RawMax);
		lim_i  = longint'(ilim_r);
		lim_d  = longint'(dlim_r);
		err    = longint'(sp_r) - longint'(meas);

		acc     = longint'(integ_r) + round_q(err * longint'(StepNum), 16);
		integ_r = 16'(clip(acc, -lim_i, lim_i));

		p_t = clip(round_q(err * longint'(gp_r), 8), raw_lo, raw_hi);
		if (p_t > lim_d || p_t < -lim_d)
			integ_r = '0;

		i_t = clip(round_q(longint'(integ_r) * longint'(gi_r), 8), raw_lo, raw_hi);
		d_t = clip(round_q(longint'(gd_r) * (err - longint'(prev_err_r)) * 10, 8),
			raw_lo, raw_hi);

		total = clip(p_t + i_t + d_t, raw_lo, raw_hi);
		drv   = clip(total, -lim_d, lim_d);

		prev_err_r  = 17'(err);
		r.drive     = 16'(drv);
		r.raw_drive = 20'(total);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		if (errors <= MaxPrinted)
			$display("mismatch on %s at result %0d: got %0d, expected %0d",
				what, results_checked, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_drive_q.size() == 0) begin
				report_mismatch("unexpected transaction", $signed(m_axis_tdata[15:0]), 0);
			end else begin
				head_r = pending_drive_q.pop_front();
				if (m_axis_tdata[15:0] !== head_r.drive)
					report_mismatch("drive", $signed(m_axis_tdata[15:0]), head_r.drive);
				if (m_axis_tdata[35:16] !== head_r.raw_drive)
					report_mismatch("raw_drive", $signed(m_axis_tdata[35:16]),
						head_r.raw_drive);
				results_checked++;
			end
		end
	end

	// watchdog: cycles without any transaction on either stream
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_count <= 0;
		end else begin
			idle_count <= idle_count + 1;
			if (idle_count >= WatchdogLimit) begin
				$display("watchdog expired with %0d results outstanding",
					pending_drive_q.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver: random stall bursts plus an optional long hold-off
	initial begin
		int burst;
		burst = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				m_axis_tready <= 1'b0;
			end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 12) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_measurement(input logic [15:0] meas);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= meas;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_drive_q.push_back(advance_pid(meas));
		last_meas = meas;
		items_sent++;
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (pending_drive_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TARGET_VALUE:   sp_r   = val;
			REG_GAIN_P:         gp_r   = val;
			REG_GAIN_I:         gi_r   = val;
			REG_GAIN_D:         gd_r   = val;
			REG_INTEGRAL_LIMIT: ilim_r = val[14:0];
			REG_DRIVE_LIMIT:    dlim_r = val[14:0];
			default: ;
		endcase
	endtask

	task automatic write_config(input logic [15:0] sp, input logic [15:0] gp,
			input logic [15:0] gi, input logic [15:0] gd,
			input logic [15:0] il, input logic [15:0] dl);
		write_reg(REG_TARGET_VALUE, sp);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_INTEGRAL_LIMIT, il);
		write_reg(REG_DRIVE_LIMIT, dl);
		settings_used++;
	endtask

	function automatic logic [15:0] pick_gain();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 2047) - 1024);
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 8191));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_measurement();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom_range(0, 65535));
			4, 5, 6, 7: return 16'(sp_r + ($urandom_range(0, 4095) - 2048));
			8: return last_meas;
			default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		endcase
	endfunction

	// reset values: zero gains, so only the integral moves
	task automatic test_reset_defaults();
		send_measurement(16'h0000);
		send_measurement(16'h7FFF);
		send_measurement(16'h8000);
		send_measurement(16'h0001);
		send_measurement(16'hFFFF);
		drain_pipeline();
	endtask

	// full-scale gains and error: P and D terms saturate, windup clears the integral; limit bit 15 is dropped
	task automatic test_full_scale();
		write_config(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
		send_measurement(16'h8000);
		send_measurement(16'h7FFF);
		send_measurement(16'h8000);
		send_measurement(16'h0000);
		drain_pipeline();
	endtask

	// zero drive and integral limits; a zero P term keeps the integral
	task automatic test_zero_limits();
		write_config(16'h1000, 16'h0100, 16'h0100, 16'h0080, 16'h0000, 16'h0000);
		send_measurement(16'h1000);
		send_measurement(16'h0000);
		send_measurement(16'h0800);
		send_measurement(16'hF000);
		drain_pipeline();
	endtask

	// writes to spare indexes must leave every register untouched
	task automatic test_spare_index();
		write_config(16'hC000, 16'h8000, 16'h0040, 16'hFF00, 16'h2000, 16'h3000);
		write_reg(RegSpare0, 16'hFFFF);
		write_reg(RegSpare1, 16'h0000);
		send_measurement(16'hC000);
		send_measurement(16'hC001);
		send_measurement(16'h7FFF);
		send_measurement(16'h8000);
		drain_pipeline();
	endtask

	task automatic test_random_settings(input int phases, input int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			src_idle_en = ($urandom_range(0, 3) != 0);
			snk_idle_en = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? RegSpare0 : RegSpare1,
					16'($urandom_range(0, 65535)));
			write_config(16'($urandom_range(0, 65535)), pick_gain(), pick_gain(),
				pick_gain(), pick_limit(), pick_limit());
			for (int i = 0; i < per_phase; i++)
				send_measurement(pick_measurement());
			drain_pipeline();
		end
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_output_backpressure();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b1;
		write_config(16'h0800, 16'h0180, 16'h0200, 16'hFFC0, 16'h1800, 16'h2000);
		hold_cycles = 200;
		for (int i = 0; i < 30; i++)
			send_measurement(pick_measurement());
		drain_pipeline();
	endtask

	task automatic test_back_to_back();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		write_config(16'($urandom_range(0, 65535)), pick_gain(), pick_gain(),
			pick_gain(), 16'h7FFF, 16'h4000);
		for (int i = 0; i < 200; i++)
			send_measurement(pick_measurement());
		drain_pipeline();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		sp_r          = '0;
		gp_r          = '0;
		gi_r          = '0;
		gd_r          = '0;
		ilim_r        = LimReset;
		dlim_r        = LimReset;
		integ_r       = '0;
		prev_err_r    = '0;
		last_meas     = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_full_scale();
		test_zero_limits();
		test_spare_index();
		test_random_settings(14, 100);
		test_output_backpressure();
		test_back_to_back();

		$display("covered %0d measurements, %0d results checked, %0d register settings",
			items_sent, results_checked, settings_used);
		$display("incl. saturating terms, zero limits, spare indexes and a long output stall");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
src/pidaw_pkg.sv
src/pidaw_seq.sv
src/pidaw_datapath.sv
src/pid_controller_antiwindup_unit.sv
tb/sv/testbench.sv
